// ----- rtl/core/oahi_pkg.sv -----
package oahi_pkg;

	localparam int VW     = 11;              // slot / size arithmetic width
	localparam int PROD_W = 19;              // accumulator times character
	localparam int CNT_W  = 5;               // counts the serial reduction steps
	localparam int TAG_BITS = 16;
	localparam int TABLE_DEPTH = 1024;       // slot fields are 10 bits wide
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_PRIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 2'd2;

	localparam logic PROBE_QUAD   = 1'b0;
	localparam logic PROBE_DOUBLE = 1'b1;

	typedef struct packed {
		logic [7:0]          key_char;
		logic                key_last;
		logic [TAG_BITS-1:0] record_tag;
	} in_word_t;

	typedef struct packed {
		logic [9:0]  slot;
		logic [9:0]  home_slot;
		logic [10:0] probe_count;
		logic        placed;
	} out_word_t;

	// insert job handed from the front to the back
	typedef struct packed {
		logic [VW-1:0]       home;
		logic [VW-1:0]       step;
		logic [TAG_BITS-1:0] tag;
	} job_t;

	typedef enum logic [2:0] {
		F_IDLE, F_MUL, F_RED, F_SRED, F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR, B_IDLE, B_READ, B_CHECK, B_OUT
	} back_state_t;

endpackage

// ----- rtl/core/open_addressing_hash_insert.sv -----
// Open-addressing hash insert. Key characters arrive one word each; the last
// character (key_last) also carries record_tag and triggers one result word.
// Each character is multiplied into the home and step accumulators, then the
// 19-bit products go through bit-serial reduction by the table size and the
// step prime, and then the next word is taken. The last character then also
// reduces the double-hash step by the table size and hands the job over,
// waiting while the queue is full. Inserts run in a separate back end behind
// a two-word queue: it takes the job, probes with a registered read of the
// valid table, and presents the result. After reset the valid table is
// cleared one slot per cycle, during which no key word is accepted;
// configuration writes are taken at any time.
module open_addressing_hash_insert import oahi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  key_valid,
	output logic                  key_ready,
	input  in_word_t              key,
	output logic                  res_valid,
	input  logic                  res_ready,
	output out_word_t             res
);

	logic [10:0] table_size_q;
	logic [9:0]  step_prime_q;
	logic        probe_mode_q;

	logic [VW-1:0] size_eff, prime_eff;
	logic          front_ready, init_done;
	logic          jq_in_valid, jq_in_ready, jq_out_valid, jq_out_ready;
	job_t          jq_in, jq_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= 11'd1021;
			step_prime_q <= 10'd347;
			probe_mode_q <= PROBE_QUAD;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TABLE_SIZE: table_size_q <= cfg_data[10:0];
				CFG_STEP_PRIME: step_prime_q <= cfg_data[9:0];
				CFG_PROBE_MODE: probe_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (table_size_q == '0)                      size_eff = VW'(1);
		else if (32'(table_size_q) > TABLE_DEPTH)    size_eff = VW'(TABLE_DEPTH);
		else                                         size_eff = table_size_q;
		prime_eff = (step_prime_q == '0) ? VW'(1) : VW'(step_prime_q);
	end

	// hold key words off until the valid table is clear
	assign key_ready = front_ready && init_done;

	oahi_front u_front (
		.clk(clk), .arst_n(arst_n),
		.key_valid(key_valid && init_done), .key_ready(front_ready), .key(key),
		.size(size_eff), .prime(prime_eff),
		.job_valid(jq_in_valid), .job_ready(jq_in_ready), .job(jq_in)
	);

	oahi_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(jq_in_valid), .push_ready(jq_in_ready), .push_word(jq_in),
		.pop_valid(jq_out_valid), .pop_ready(jq_out_ready), .pop_word(jq_out)
	);

	oahi_back u_back (
		.clk(clk), .arst_n(arst_n),
		.size(size_eff), .mode(probe_mode_q),
		.job_valid(jq_out_valid), .job_ready(jq_out_ready), .job(jq_out),
		.init_done(init_done),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

endmodule

// ----- rtl/core/oahi_modred.sv -----
// value mod modulus, one bit of value per cycle, MSB first
module oahi_modred import oahi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] value,
	input  logic [VW-1:0]     modulus,
	output logic [VW-1:0]     result,
	output logic              busy
);

	logic [PROD_W-1:0] v_q;
	logic [VW-1:0]     r_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VW:0]       t;

	always_comb begin
		t = {r_q, v_q[PROD_W-1]};
		if (t >= {1'b0, modulus}) begin
			t = t - {1'b0, modulus};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(PROD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			r_q <= '0;
		end else if (cnt_q != '0) begin
			v_q <= {v_q[PROD_W-2:0], 1'b0};
			r_q <= t[VW-1:0];
		end
	end

	assign result = r_q;
	assign busy   = (cnt_q != '0);

endmodule

// ----- rtl/core/oahi_front.sv -----
module oahi_front import oahi_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          key_valid,
	output logic          key_ready,
	input  in_word_t      key,
	input  logic [VW-1:0] size,
	input  logic [VW-1:0] prime,
	output logic          job_valid,
	input  logic          job_ready,
	output job_t          job
);

	front_state_t state_q, state_nxt;

	logic [7:0]          ch_q;
	logic                last_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [VW-1:0]       home_q, step_q, homer_q;

	logic              start_h, start_s;
	logic [PROD_W-1:0] val_h, prod_h, prod_s;
	logic [VW-1:0]     res_h, res_s;
	logic              busy_h, busy_s;

	assign prod_h = PROD_W'(home_q) * PROD_W'(ch_q);
	assign prod_s = PROD_W'(step_q) * PROD_W'(ch_q);
	// second pass on the home reducer: (prime - reduced step product) mod size
	assign val_h  = (state_q == F_MUL) ? prod_h : PROD_W'(prime - res_s);

	oahi_modred u_red_home (
		.clk(clk), .arst_n(arst_n), .start(start_h), .value(val_h),
		.modulus(size), .result(res_h), .busy(busy_h)
	);

	oahi_modred u_red_step (
		.clk(clk), .arst_n(arst_n), .start(start_s), .value(prod_s),
		.modulus(prime), .result(res_s), .busy(busy_s)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			F_IDLE: if (key_valid) state_nxt = F_MUL;
			F_MUL:  state_nxt = F_RED;
			F_RED: begin
				if (!busy_h && !busy_s) state_nxt = last_q ? F_SRED : F_IDLE;
			end
			F_SRED: if (!busy_h) state_nxt = F_PUSH;
			F_PUSH: if (job_ready) state_nxt = F_IDLE;
			default: state_nxt = F_IDLE;
		endcase
	end

	always_comb begin
		key_ready = (state_q == F_IDLE);
		start_h   = (state_q == F_MUL) ||
		            (state_q == F_RED && !busy_h && !busy_s && last_q);
		start_s   = (state_q == F_MUL);
		job_valid = (state_q == F_PUSH);
		job.home  = homer_q;
		job.step  = res_h;
		job.tag   = tag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			home_q  <= VW'(1);
			step_q  <= VW'(1);
		end else begin
			state_q <= state_nxt;
			if (state_q == F_RED && !busy_h && !busy_s && !last_q) begin
				home_q <= res_h;
				step_q <= res_s;
			end
			if (state_q == F_PUSH && job_ready) begin
				home_q <= VW'(1);
				step_q <= VW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && key_valid) begin
			ch_q   <= key.key_char;
			last_q <= key.key_last;
			tag_q  <= key.record_tag;
		end
		if (state_q == F_RED && !busy_h && !busy_s) begin
			homer_q <= res_h;
		end
	end

endmodule

// ----- rtl/core/oahi_queue.sv -----
// two-word job queue between front and back
module oahi_queue import oahi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_word,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_word
);

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_word   = mem_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop)  rp_q <= ~rp_q;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= push_word;
	end

endmodule

// ----- rtl/core/oahi_back.sv -----
module oahi_back import oahi_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [VW-1:0] size,
	input  logic          mode,
	input  logic          job_valid,
	output logic          job_ready,
	input  job_t          job,
	output logic          init_done,
	output logic          res_valid,
	input  logic          res_ready,
	output out_word_t     res
);

	localparam int IW = $clog2(TABLE_DEPTH);

	back_state_t state_q, state_nxt;

	logic                   valid_mem [TABLE_DEPTH];
	logic [10+TAG_BITS-1:0] entry_mem [TABLE_DEPTH];

	logic [IW:0]         clr_q;
	logic [VW-1:0]       j_q, d_q, home_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [10:0]         probes_q;
	logic                rd_q, placed_q;

	logic          mem_we, mem_wd;
	logic [IW-1:0] mem_addr;
	logic [VW:0]   j_sum, d_sum;
	logic          hit, full;

	assign hit  = !rd_q;
	assign full = (probes_q == size);

	always_comb begin
		j_sum = {1'b0, j_q} + {1'b0, d_q};
		if (j_sum >= {1'b0, size}) j_sum = j_sum - {1'b0, size};
		// odd increment of the quadratic offset; size one needs two wraps
		d_sum = {1'b0, d_q} + (VW+1)'(2);
		if (d_sum >= {1'b0, size}) d_sum = d_sum - {1'b0, size};
		if (d_sum >= {1'b0, size}) d_sum = d_sum - {1'b0, size};
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			B_CLEAR: if (clr_q == (IW+1)'(TABLE_DEPTH - 1)) state_nxt = B_IDLE;
			B_IDLE:  if (job_valid) state_nxt = B_READ;
			B_READ:  state_nxt = B_CHECK;
			B_CHECK: state_nxt = (hit || full) ? B_OUT : B_READ;
			B_OUT:   if (res_ready) state_nxt = B_IDLE;
			default: state_nxt = B_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (state_q == B_IDLE);
		init_done = (state_q != B_CLEAR);
		res_valid = (state_q == B_OUT);
		mem_we    = (state_q == B_CLEAR) || (state_q == B_CHECK && hit);
		mem_wd    = (state_q != B_CLEAR);
		mem_addr  = (state_q == B_CLEAR) ? clr_q[IW-1:0] : IW'(j_q);
		res.slot        = placed_q ? j_q[9:0] : 10'd0;
		res.home_slot   = home_q[9:0];
		res.probe_count = probes_q;
		res.placed      = placed_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			valid_mem[mem_addr] <= mem_wd;
		end
		if (state_q == B_CHECK && hit) begin
			entry_mem[mem_addr] <= {home_q[9:0], tag_q};
		end
		rd_q <= valid_mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == B_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					j_q      <= job.home;
					home_q   <= job.home;
					tag_q    <= job.tag;
					probes_q <= '0;
					if (mode == PROBE_DOUBLE) d_q <= job.step;
					else                      d_q <= (size == VW'(1)) ? '0 : VW'(1);
				end
			end
			B_READ: probes_q <= probes_q + 1'b1;
			B_CHECK: begin
				placed_q <= hit;
				if (!hit && !full) begin
					j_q <= j_sum[VW-1:0];
					if (mode == PROBE_QUAD) d_q <= d_sum[VW-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- sim/tb.sv -----
module tb;
	import oahi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = TABLE_DEPTH;
	localparam int LIMIT = 5000000;
	localparam int DRAIN = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic key_valid = 1'b0;
	logic key_ready;
	in_word_t key = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	out_word_t res;

	open_addressing_hash_insert uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.key_valid(key_valid), .key_ready(key_ready), .key(key),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always #4 clk = ~clk;

	// shadow of the block
	int unsigned tbl_size = 1021;
	int unsigned step_prm = 347;
	bit dbl_mode = 1'b0;
	int unsigned home_acc = 1;
	int unsigned step_acc = 1;
	bit slot_used [DEPTH];

	out_word_t inserts_due [$];
	int errors = 0;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	typedef struct {
		bit is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		in_word_t w;
		bit typed;
		out_word_t want;
	} row_t;
	row_t rows [$];

	function automatic void hash_insert(input in_word_t w, output bit got,
			output out_word_t r);
		int unsigned size, sp, home, j, probes, stp;
		longint unsigned i;
		bit ok;
		size = (tbl_size < 1) ? 1 : tbl_size;
		if (size > DEPTH) size = DEPTH;
		sp = (step_prm < 1) ? 1 : step_prm;
		home_acc = ((home_acc % size) * w.key_char) % size;
		step_acc = ((step_acc % sp) * w.key_char) % sp;
		got = w.key_last;
		r = '0;
		if (!w.key_last) return;
		home = home_acc;
		j = 0;
		probes = 0;
		ok = 1'b0;
		if (dbl_mode == PROBE_QUAD) begin
			for (i = 0; i < size; i++) begin
				j = 32'((home + i * i) % size);
				probes++;
				if (!slot_used[j]) begin
					ok = 1'b1;
					break;
				end
			end
		end else begin
			stp = sp - step_acc;
			j = home;
			while (probes < size) begin
				probes++;
				if (!slot_used[j]) begin
					ok = 1'b1;
					break;
				end
				j = (j + stp) % size;
			end
		end
		if (ok) slot_used[j] = 1'b1;
		else j = 0;
		r.slot = j[9:0];
		r.home_slot = home[9:0];
		r.probe_count = probes[10:0];
		r.placed = ok;
		home_acc = 1;
		step_acc = 1;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TABLE_SIZE: tbl_size = 32'(d);
			CFG_STEP_PRIME: step_prm = 32'(d[9:0]);
			CFG_PROBE_MODE: dbl_mode = d[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// front end may still be chewing on a character with nothing queued
	task automatic wait_quiet();
		while (inserts_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
		bit got;
		out_word_t r;
		key_valid <= 1'b1;
		key <= w;
		do @(posedge clk); while (!key_ready);
		hash_insert(w, got, r);
		if (got) inserts_due.insert(inserts_due.size(), typed ? want : r);
		if ($urandom_range(0, 99) < idle_pct) begin
			key_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		row_t x;
		x = '{default: '0};
		x.is_cfg = 1'b1;
		x.idx = idx;
		x.data = d;
		rows.insert(rows.size(), x);
	endfunction

	function automatic void add_key(input logic [7:0] ch, input bit last, input logic [15:0] tag,
			input bit typed, input logic [9:0] s, input logic [9:0] h,
			input logic [10:0] p, input bit ok);
		row_t x;
		x = '{default: '0};
		x.w = '{key_char: ch, key_last: last, record_tag: tag};
		x.typed = typed;
		x.want = '{slot: s, home_slot: h, probe_count: p, placed: ok};
		rows.insert(rows.size(), x);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("open_addressing_hash_insert verification failed");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= 600;
				res_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
			if (res_valid && res_ready) begin
				if (inserts_due.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result word %h", res);
				end else begin
					e = inserts_due.pop_front();
					if (res !== e) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: exp slot %0d home %0d probes %0d placed %0d",
								e.slot, e.home_slot, e.probe_count, e.placed);
							$display("          got slot %0d home %0d probes %0d placed %0d",
								res.slot, res.home_slot, res.probe_count, res.placed);
						end
					end
				end
			end
		end
	end

	initial begin
		int ph, n, len, k, pick;
		in_word_t w;
		int unsigned sizes [12];
		sizes = '{2, 3, 5, 7, 11, 13, 31, 97, 1021, 1024, 2047, 0};

		// directed
		add_key(8'd0, 1, 16'h0000, 1, 10'd0, 10'd0, 11'd1, 1);
		add_key(8'd255, 1, 16'hFFFF, 1, 10'd255, 10'd255, 11'd1, 1);
		add_key(8'd255, 1, 16'h1234, 1, 10'd256, 10'd255, 11'd2, 1);   // one collision
		add_key(8'd2, 0, 16'hFFFF, 0, 0, 0, 0, 0);
		add_key(8'd3, 1, 16'h5A5A, 0, 0, 0, 0, 0);
		add_cfg(CFG_TABLE_SIZE, 11'd0);                                  // size zero acts as one
		add_key(8'd7, 1, 16'hA5A5, 1, 10'd0, 10'd0, 11'd1, 0);
		add_cfg(CFG_TABLE_SIZE, 11'h7FF);                                // saturates to depth
		add_cfg(CFG_PROBE_MODE, CFG_DATA_W'(PROBE_DOUBLE));
		add_cfg(CFG_STEP_PRIME, 11'd0);                                  // prime zero acts as one
		add_key(8'd255, 1, 16'h0F0F, 1, 10'd257, 10'd255, 11'd3, 1);
		add_cfg(CFG_STEP_PRIME, 11'h7FF);
		add_cfg(CFG_TABLE_SIZE, 11'd2);
		add_key(8'd1, 1, 16'h0001, 0, 0, 0, 0, 0);
		add_key(8'd1, 1, 16'h8000, 1, 10'd0, 10'd1, 11'd2, 0);          // full, double hash
		add_cfg(CFG_PROBE_MODE, CFG_DATA_W'(PROBE_QUAD));
		add_key(8'd0, 1, 16'h7FFF, 1, 10'd0, 10'd0, 11'd2, 0);          // full, quadratic
		add_cfg(CFG_TABLE_SIZE, 11'd1021);
		add_cfg(CFG_STEP_PRIME, 11'd347);
		add_key(8'd200, 0, 16'h0000, 0, 0, 0, 0, 0);
		add_cfg(CFG_TABLE_SIZE, 11'd97);                                 // changed mid-key
		add_key(8'd100, 1, 16'hC3C3, 0, 0, 0, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			if (rows[r].is_cfg) begin
				key_valid <= 1'b0;
				wait_quiet();
				write_reg(rows[r].idx, rows[r].data);
			end else begin
				send_word(rows[r].w, rows[r].typed, rows[r].want);
			end
		end

		// random phases
		for (ph = 0; ph < 10; ph++) begin
			key_valid <= 1'b0;
			wait_quiet();
			idle_pct = (ph % 4 == 1) ? 75 : (ph % 4 == 3) ? 32 : 0;
			stall_pct = (ph % 4 == 2) ? 75 : (ph % 4 == 3) ? 32 : 0;
			pick = $urandom_range(0, 11);
			write_reg(CFG_TABLE_SIZE, CFG_DATA_W'((pick == 11) ?
				$urandom_range(2, 1024) : sizes[pick]));
			write_reg(CFG_STEP_PRIME, CFG_DATA_W'($urandom_range(0, 2047)));
			write_reg(CFG_PROBE_MODE, CFG_DATA_W'($urandom_range(0, 1)));
			if (ph == 4) hold_req++;   // long receiver hold, sender keeps offering
			n = 0;
			while (n < 68) begin
				len = $urandom_range(1, 4);
				for (k = 0; k < len; k++) begin
					w.key_char = 8'($urandom_range(0, 255));
					w.key_last = (k == len - 1);
					w.record_tag = 16'($urandom_range(0, 65535));
					// some keys are left open across the next register change
					if (n == 67 && $urandom_range(0, 1)) w.key_last = 1'b0;
					send_word(w, 1'b0, '0);
					n++;
				end
			end
		end

		key_valid <= 1'b0;
		while (inserts_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && inserts_due.size() == 0) begin
			$display("open_addressing_hash_insert verification clean");
		end else begin
			$display("open_addressing_hash_insert verification failed");
		end
		$finish;
	end

endmodule
